@@ hw/rtl/dmsg_pkg.sv @@
`timescale 1ns / 1ps
// dmsg_pkg: widths, mode and register codes, and the quarter-wave sine table
// for the modulator sample generator. No dependencies.

package dmsg_pkg;

    // Fixed datapath widths
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int SAMPLE_BITS     = 16;
    localparam int QTR_BITS        = TABLE_ADDR_BITS - 2;
    localparam int N4              = 2 ** QTR_BITS;
    localparam int MAG_BITS        = SAMPLE_BITS - 2;
    localparam int ROUND_SHIFT     = 33 - SAMPLE_BITS;
    // Deviation product to phase units; non-negative for these widths
    localparam int DEV_SHIFT       = PHASE_BITS - SAMPLE_BITS - 12;
    localparam int DEV_BITS        = 16;
    localparam int ADDR_BITS       = 5;
    localparam int DATA_BITS       = 32;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [TABLE_ADDR_BITS-1:0] QUARTER_ADDR = TABLE_ADDR_BITS'(N4);

    typedef logic signed [SAMPLE_BITS-1:0]     t_smp;
    typedef logic [N4-1:0][MAG_BITS-1:0]       t_qtab;

    // Modulation modes
    localparam logic [2:0] MODE_BPSK     = 3'd0;
    localparam logic [2:0] MODE_BFSK     = 3'd1;
    localparam logic [2:0] MODE_BASK     = 3'd2;
    localparam logic [2:0] MODE_QAM4     = 3'd3;
    localparam logic [2:0] MODE_CARRIER  = 3'd4;
    localparam logic [2:0] MODE_PASSBAND = 3'd5;
    localparam logic [2:0] MODE_TONE     = 3'd6;

    // Register indexes (word address)
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_OUT_CHAN  = 3'd1;
    localparam logic [2:0] REG_BB_STEP   = 3'd2;
    localparam logic [2:0] REG_PB_STEP   = 3'd3;
    localparam logic [2:0] REG_SYM_STEP  = 3'd4;
    localparam logic [2:0] REG_DEV       = 3'd5;

    // Sine magnitude of quarter-wave offset r: Taylor series to x^11 in Q30,
    // clamped at zero, rounded half up to the sample format.
    function automatic logic [MAG_BITS-1:0] sine_mag(input int unsigned r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] acc;
        logic signed [63:0] s;
        x   = (64'(r) * HALF_PI_Q30) >> QTR_BITS;
        x2  = (x * x) >> 30;
        t   = x;
        acc = signed'(x);
        t   = ((t * x2) >> 30) / 64'd6;
        acc = acc - signed'(t);
        t   = ((t * x2) >> 30) / 64'd20;
        acc = acc + signed'(t);
        t   = ((t * x2) >> 30) / 64'd42;
        acc = acc - signed'(t);
        t   = ((t * x2) >> 30) / 64'd72;
        acc = acc + signed'(t);
        t   = ((t * x2) >> 30) / 64'd110;
        acc = acc - signed'(t);
        if (acc < 0) begin
            acc = 64'sd0;
        end
        s = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        return s[MAG_BITS-1:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int i = 0; i < N4; i++) begin
            tab[i] = sine_mag(unsigned'(i));
        end
        return tab;
    endfunction

    // Quarter-wave table (offsets 0 .. N4-1) and the peak at exactly pi/2
    localparam t_qtab SIN_QTAB = build_qtab();
    localparam logic [MAG_BITS-1:0] SIN_PEAK = sine_mag(unsigned'(N4));

endpackage

@@ hw/rtl/digital_modulator_sample_generator.sv @@
`timescale 1ns / 1ps
// digital_modulator_sample_generator: NCO-based BPSK/BFSK/BASK/4QAM modulator
// with phase-modulated passband output. Depends on dmsg_pkg.
//
// Usage
//   Input channel (i_valid / o_stall): one transfer per sample tick, carrying
//   the current symbol's bits. Each transfer yields exactly one result.
//   Output channel (o_valid / i_stall): the sample and a flag that marks the
//   last sample of a symbol (symbol clock carry).
//   Registers are written over the APB port (psel/penable/pwrite/paddr/
//   pwdata); pready is tied high and reads return the register contents.
//   From input transfer to output transfer a sample passes through the input
//   register, the baseband stage, the deviation multiply and the passband
//   lookup into the output register.
//   Throughput is one sample per cycle while the receiver does not stall; the
//   deviation multiply sits in its own stage between the baseband and passband table lookups.
//   While the receiver stalls, the output holds and items move up into empty
//   stages; the input stalls only once every stage is full.
//   Reset clears the phase accumulators and stage valids and loads the
//   register defaults (carrier mode, passband output).
//   Registers are to be written only while no item is in flight.

module digital_modulator_sample_generator
    import dmsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_symbol_bits,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_sample,
    output logic                  o_symbol_end,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Signed sine from the top phase bits, using quarter-wave symmetry
    function automatic t_smp rom_read(input logic [TABLE_ADDR_BITS-1:0] a);
        logic [QTR_BITS:0]   r;
        logic [MAG_BITS-1:0] mag;
        t_smp                v;
        r = {1'b0, a[QTR_BITS-1:0]};
        if (a[QTR_BITS]) begin
            r = (QTR_BITS + 1)'(N4) - r;
        end
        mag = r[QTR_BITS] ? SIN_PEAK : SIN_QTAB[r[QTR_BITS-1:0]];
        v   = {2'b00, mag};
        return a[TABLE_ADDR_BITS-1] ? -v : v;
    endfunction

    function automatic t_smp sat_smp(input logic signed [SAMPLE_BITS:0] v);
        logic signed [SAMPLE_BITS:0] hi;
        logic signed [SAMPLE_BITS:0] lo;
        hi = (SAMPLE_BITS + 1)'((2 ** (SAMPLE_BITS - 1)) - 1);
        lo = -((SAMPLE_BITS + 1)'(2 ** (SAMPLE_BITS - 1)));
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end
        if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]             r_mode;
    logic                   r_out_chan;
    logic [PHASE_BITS-1:0]  r_bb_step;
    logic [PHASE_BITS-1:0]  r_pb_step;
    logic [PHASE_BITS-1:0]  r_sym_step;
    logic signed [DEV_BITS-1:0] r_dev;
    logic                   w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CARRIER;
            r_out_chan <= 1'b1;
            r_bb_step  <= PHASE_BITS'(97392);
            r_pb_step  <= PHASE_BITS'(486957743);
            r_sym_step <= PHASE_BITS'(97392);
            r_dev      <= DEV_BITS'(2086);
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_MODE:     r_mode     <= pwdata[2:0];
                REG_OUT_CHAN: r_out_chan <= pwdata[0];
                REG_BB_STEP:  r_bb_step  <= pwdata[PHASE_BITS-1:0];
                REG_PB_STEP:  r_pb_step  <= pwdata[PHASE_BITS-1:0];
                REG_SYM_STEP: r_sym_step <= pwdata[PHASE_BITS-1:0];
                REG_DEV:      r_dev      <= pwdata[DEV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[4:2])
            REG_MODE:     prdata = {29'd0, r_mode};
            REG_OUT_CHAN: prdata = {31'd0, r_out_chan};
            REG_BB_STEP:  prdata = r_bb_step;
            REG_PB_STEP:  prdata = r_pb_step;
            REG_SYM_STEP: prdata = r_sym_step;
            REG_DEV:      prdata = {{(DATA_BITS - DEV_BITS){r_dev[DEV_BITS-1]}}, r_dev};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when it is empty or
    // its content moves on in the same cycle
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic w_in_xfer;

    assign w_rdy4    = !r_s4_valid || !i_stall;
    assign w_rdy3    = !r_s3_valid || w_rdy4;
    assign w_rdy2    = !r_s2_valid || w_rdy3;
    assign w_rdy1    = !r_s1_valid || w_rdy2;
    assign o_stall   = !w_rdy1;
    assign w_in_xfer = i_valid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_valid <= i_valid;
            if (w_rdy2) r_s2_valid <= r_s1_valid;
            if (w_rdy3) r_s3_valid <= r_s2_valid;
            if (w_rdy4) r_s4_valid <= r_s3_valid;
        end
    end

    // ------------------------------------------------------------------
    // Phase accumulators, advanced once per input transfer
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] r_bb_phase;
    logic [PHASE_BITS-1:0] r_pb_phase;
    logic [PHASE_BITS-1:0] r_sym_phase;
    logic [PHASE_BITS:0]   n_sym_sum;

    assign n_sym_sum = {1'b0, r_sym_phase} + {1'b0, r_sym_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bb_phase  <= '0;
            r_pb_phase  <= '0;
            r_sym_phase <= '0;
        end else if (w_in_xfer) begin
            r_bb_phase  <= r_bb_phase + r_bb_step;
            r_pb_phase  <= r_pb_phase + r_pb_step;
            r_sym_phase <= n_sym_sum[PHASE_BITS-1:0];
        end
    end

    // Stage 1: input register with the phases as they stood before the tick
    logic [1:0]            r_s1_bits;
    logic [PHASE_BITS-1:0] r_s1_bb_phase;
    logic [PHASE_BITS-1:0] r_s1_pb_phase;
    logic                  r_s1_end;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_bits     <= i_symbol_bits;
            r_s1_bb_phase <= r_bb_phase;
            r_s1_pb_phase <= r_pb_phase;
            r_s1_end      <= n_sym_sum[PHASE_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: baseband value per mode
    // ------------------------------------------------------------------
    t_smp                        w_cb;
    t_smp                        w_ch;
    t_smp                        w_sb;
    logic signed [SAMPLE_BITS:0] w_cb_ext;
    logic signed [SAMPLE_BITS:0] w_sb_ext;
    logic signed [SAMPLE_BITS:0] w_half_tmp;
    logic signed [SAMPLE_BITS:0] w_qam_sum;
    t_smp                        n_bb;
    logic                        w_b0;
    logic                        w_b1;

    assign w_b0 = r_s1_bits[0];
    assign w_b1 = r_s1_bits[1];

    always_comb begin
        w_cb = rom_read(r_s1_bb_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS] + QUARTER_ADDR);
        // half-frequency carrier: cosine of the phase shifted down by one
        w_ch = rom_read({1'b0, r_s1_bb_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS-1]}
                        + QUARTER_ADDR);
        w_sb = rom_read(r_s1_bb_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS]);

        w_cb_ext = {w_cb[SAMPLE_BITS-1], w_cb};
        w_sb_ext = {w_sb[SAMPLE_BITS-1], w_sb};
        // halve, truncating toward zero
        w_half_tmp = w_cb_ext + $signed({{SAMPLE_BITS{1'b0}}, w_cb[SAMPLE_BITS-1]});
        w_qam_sum  = (w_b0 ? -w_cb_ext : w_cb_ext) + (w_b1 ? -w_sb_ext : w_sb_ext);

        unique case (r_mode) inside
            MODE_BPSK:              n_bb = w_b0 ? -w_cb : w_cb;
            MODE_BFSK:              n_bb = w_b0 ? w_cb : w_ch;
            MODE_BASK:              n_bb = w_b0 ? w_cb : t_smp'(w_half_tmp >>> 1);
            MODE_QAM4:              n_bb = sat_smp(w_qam_sum);
            MODE_CARRIER, MODE_TONE: n_bb = w_cb;
            default:                n_bb = '0;
        endcase
    end

    t_smp                  r_s2_bb;
    logic [PHASE_BITS-1:0] r_s2_pb_phase;
    logic                  r_s2_end;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_rdy2) begin
            r_s2_bb       <= n_bb;
            r_s2_pb_phase <= r_s1_pb_phase;
            r_s2_end      <= r_s1_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: deviation times baseband
    // ------------------------------------------------------------------
    logic signed [DEV_BITS+SAMPLE_BITS-1:0] r_s3_prod;
    t_smp                                   r_s3_bb;
    logic [PHASE_BITS-1:0]                  r_s3_pb_phase;
    logic                                   r_s3_end;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && w_rdy3) begin
            r_s3_prod     <= (DEV_BITS + SAMPLE_BITS)'(r_dev)
                             * (DEV_BITS + SAMPLE_BITS)'(r_s2_bb);
            r_s3_bb       <= r_s2_bb;
            r_s3_pb_phase <= r_s2_pb_phase;
            r_s3_end      <= r_s2_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: modulated passband phase, lookup (bypassed in carrier mode) and channel select
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] w_pm_phase;
    t_smp                  w_pb;
    t_smp                  n_sample;

    always_comb begin
        w_pm_phase = r_s3_pb_phase + (PHASE_BITS'(r_s3_prod) << DEV_SHIFT);
        if (r_mode == MODE_CARRIER) begin
            w_pb = r_s3_bb;
        end else begin
            w_pb = rom_read(w_pm_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS] + QUARTER_ADDR);
        end
        n_sample = r_out_chan ? w_pb : r_s3_bb;
    end

    t_smp r_s4_sample;
    logic r_s4_end;

    always_ff @(posedge i_clk) begin
        if (r_s3_valid && w_rdy4) begin
            r_s4_sample <= n_sample;
            r_s4_end    <= r_s3_end;
        end
    end

    assign o_valid      = r_s4_valid;
    assign o_sample     = r_s4_sample;
    assign o_symbol_end = r_s4_end;

endmodule

@@ hw/rtl/dmsg_checker.sv @@
`timescale 1ns / 1ps
// dmsg_checker: port-level assertions for the modulator sample generator,
// attached to the top level by the bind below. Uses no package.

module dmsg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_sample,
    input logic               o_symbol_end
);

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample) && $stable(o_symbol_end))
        else $error("stalled output changed");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // With an empty output register the input never stalls
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output empty");

    // An input transfer reaches the output while the receiver keeps taking results
    a_latency: assert property (@(posedge i_clk)
        $past(i_valid && !o_stall, 3) && $past(i_rst_n, 3)
        && $past(i_rst_n, 2) && $past(!i_stall, 2)
        && $past(i_rst_n, 1) && $past(!i_stall, 1)
        && i_rst_n && !i_stall |=> o_valid)
        else $error("result missing four cycles after transfer");

endmodule

bind digital_modulator_sample_generator dmsg_checker u_dmsg_checker (.*);
